FILE: src/charlieplexed_segment_display_scan_assert.svh
// Assertion macros used by the display scanner port checker
`ifndef CHARLIEPLEXED_SEGMENT_DISPLAY_SCAN_ASSERT_SVH
`define CHARLIEPLEXED_SEGMENT_DISPLAY_SCAN_ASSERT_SVH

// same-cycle implication, held off during reset
`define CSDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define CSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/csds_pkg.sv
// Types, constants and decode tables for the charlieplexed display scanner
package csds_pkg;

	localparam int NUM_BYTES = 5;
	localparam int NUM_SEGS  = 7;
	localparam int NUM_PINS  = 6;
	localparam int NUM_MAP   = NUM_BYTES * NUM_SEGS;

	localparam logic [2:0] CURSOR_END = 3'd5;
	localparam logic [2:0] LAST_PHASE = 3'd5;
	localparam logic [2:0] NIL        = 3'd7;
	localparam logic [7:0] DASH       = 8'h40;
	localparam int         COLON_BIT  = 4;
	localparam int         STATUS_IDX = 4;

	typedef enum logic [1:0] {
		OP_PUT_CHAR     = 2'd0,
		OP_SET_CURSOR   = 2'd1,
		OP_WRITE_STATUS = 2'd2,
		OP_SCAN_TICK    = 2'd3
	} op_t;

	typedef enum logic {
		REG_BLINK_CHAR = 1'b0,
		REG_BLINK_ICON = 1'b1
	} reg_idx_t;

	typedef logic [NUM_BYTES-1:0][7:0] disp_bytes_t;

	typedef struct packed {
		logic [4:0] char_mask;
		logic [7:0] icon_mask;
	} blink_cfg_t;

	localparam logic [7:0] DIGIT_SEG [0:9] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	localparam logic [7:0] UPPER_SEG [0:25] = '{
		8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h40,
		8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h78,
		8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h40
	};

	localparam logic [7:0] LOWER_SEG [0:25] = '{
		8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h06, 8'h40,
		8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h78,
		8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
	};

	// pin pair per (byte, segment), entry = byte*7 + segment; NIL = not wired
	localparam logic [2:0] PIN_HI [0:NUM_MAP-1] = '{
		NIL,  3'd3, 3'd4, NIL,  NIL,  NIL,  NIL,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd3,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd5,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
		NIL,  NIL,  NIL,  NIL,  NIL,  NIL,  3'd5
	};

	localparam logic [2:0] PIN_LO [0:NUM_MAP-1] = '{
		NIL,  3'd2, 3'd2, NIL,  NIL,  NIL,  NIL,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd1,
		3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5,
		NIL,  NIL,  NIL,  NIL,  NIL,  NIL,  3'd2
	};

	// ASCII to segment pattern; colon is handled by the caller
	function automatic logic [7:0] char_seg(input logic [7:0] c);
		logic [7:0] seg;
		seg = DASH;
		if (c >= 8'h30 && c <= 8'h39)
			seg = DIGIT_SEG[4'(c - 8'h30)];
		else if (c >= 8'h61 && c <= 8'h7a)
			seg = LOWER_SEG[5'(c - 8'h61)];
		else if (c >= 8'h41 && c <= 8'h5a)
			seg = UPPER_SEG[5'(c - 8'h41)];
		else if (c == 8'h20)
			seg = 8'h00;
		return seg;
	endfunction

endpackage

FILE: src/csds_render.sv
// Blink masking and segment-to-pin mapping for one scan phase
module csds_render import csds_pkg::*; (
	input  disp_bytes_t disp,
	input  blink_cfg_t  blink_cfg,
	input  logic        hide,
	input  logic [2:0]  phase,
	output logic [5:0]  drive_low
);

	disp_bytes_t shown;

	always_comb begin
		for (int i = 0; i < NUM_BYTES; i++) begin
			shown[i] = disp[i];
			if (hide) begin
				if (blink_cfg.icon_mask != 8'h00 && i == STATUS_IDX)
					shown[i] = disp[i] & ~blink_cfg.icon_mask;
				else if (blink_cfg.char_mask[i])
					shown[i] = 8'h00;
			end
		end
	end

	always_comb begin
		drive_low = '0;
		for (int k = 0; k < NUM_MAP; k++) begin
			if (shown[k / NUM_SEGS][k % NUM_SEGS] && PIN_HI[k] == phase) begin
				for (int l = 0; l < NUM_PINS; l++) begin
					if (PIN_LO[k] == 3'(l))
						drive_low[l] = 1'b1;
				end
			end
		end
	end

endmodule

FILE: src/charlieplexed_segment_display_scan.sv
// An item is registered in the input register, then processed; a scan tick loads the result register.
// Throughput: 1 item per cycle; a scan tick waits only while the result register is full.
// The result register frees in the cycle m_tready takes it, so input keeps flowing.
// Reset (arst_n low, asynchronous): blank display, cursor 0, phase 0, blink masks 0,
// no item or result pending.
module charlieplexed_segment_display_scan import csds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // value[7:0], blink_phase[8], zero[15:9]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // drive_high[5:0], drive_low[11:6], scan_phase[14:12], zero[15]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	op_t         op_s1;
	logic        in_valid_s1;
	logic [7:0]  value_s1;
	logic        blink_s1;

	disp_bytes_t disp_q;
	logic [2:0]  cursor_q;
	logic [2:0]  phase_q;
	blink_cfg_t  blink_cfg_q;

	logic        out_valid_q;
	logic [5:0]  drive_high_q;
	logic [5:0]  drive_low_q;
	logic [2:0]  scan_phase_q;

	logic        out_free;
	logic        fire_s1;
	logic        cfg_wr;
	logic [5:0]  drive_low;

	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = in_valid_s1 && (op_s1 != OP_SCAN_TICK || out_free);
	assign s_tready = !in_valid_s1 || fire_s1;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_BLINK_CHAR: blink_cfg_q.char_mask <= pwdata[4:0];
				REG_BLINK_ICON: blink_cfg_q.icon_mask <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_BLINK_CHAR: prdata = {27'd0, blink_cfg_q.char_mask};
			REG_BLINK_ICON: prdata = {24'd0, blink_cfg_q.icon_mask};
			default:        prdata = '0;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= op_t'(s_tuser);
			value_s1 <= s_tdata[7:0];
			blink_s1 <= s_tdata[8];
		end
	end

	// display store, cursor and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q   <= '0;
			cursor_q <= '0;
			phase_q  <= '0;
		end else if (fire_s1) begin
			case (op_s1)
				OP_PUT_CHAR: begin
					if (value_s1 == 8'h3a) begin
						disp_q[STATUS_IDX][COLON_BIT] <= 1'b1;
					end else if (cursor_q < CURSOR_END) begin
						disp_q[cursor_q] <= char_seg(value_s1);
						cursor_q         <= cursor_q + 3'd1;
					end
				end
				OP_SET_CURSOR: begin
					cursor_q <= (value_s1 > 8'(CURSOR_END)) ? CURSOR_END : value_s1[2:0];
				end
				OP_WRITE_STATUS: begin
					disp_q[STATUS_IDX] <= value_s1;
				end
				OP_SCAN_TICK: begin
					phase_q <= (phase_q == LAST_PHASE) ? 3'd0 : phase_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	csds_render u_render (
		.disp      (disp_q),
		.blink_cfg (blink_cfg_q),
		.hide      (blink_s1),
		.phase     (phase_q),
		.drive_low (drive_low)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && op_s1 == OP_SCAN_TICK) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && op_s1 == OP_SCAN_TICK) begin
			drive_high_q <= 6'b1 << phase_q;
			drive_low_q  <= drive_low;
			scan_phase_q <= phase_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, scan_phase_q, drive_low_q, drive_high_q};

endmodule

FILE: src/csds_checker.sv
// Port-level checker for the display scanner, bound to the top level
`include "charlieplexed_segment_display_scan_assert.svh"

module csds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`CSDS_ASSERT_IMP(a_phase_range, clk, arst_n, m_tvalid, m_tdata[14:12] <= 3'd5, "scan phase out of range")
	`CSDS_ASSERT_IMP(a_high_matches_phase, clk, arst_n, m_tvalid, m_tdata[5:0] == (6'b1 << m_tdata[14:12]), "high drive does not match phase")
	`CSDS_ASSERT_IMP(a_no_pin_conflict, clk, arst_n, m_tvalid, (m_tdata[5:0] & m_tdata[11:6]) == 6'd0, "pin driven high and low")
	`CSDS_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

endmodule

bind charlieplexed_segment_display_scan csds_checker u_csds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: sim/scan_drive_checker.sv
`timescale 1ns / 100ps
// Checker for the display scanner: mirrors the display store and compares every pin drive
module scan_drive_checker import csds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // value[7:0], blink_phase[8], zero[15:9]
	input  logic [1:0]  s_tuser,  // op[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // drive_high[5:0], drive_low[11:6], scan_phase[14:12], zero[15]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          pending_count
);

	localparam logic [7:0] ASCII_COLON = 8'h3a;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	typedef struct packed {
		logic [5:0] high;
		logic [5:0] low;
		logic [2:0] phase;
	} pin_drive_t;

	localparam logic [7:0] SEG_DIGIT [0:9] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	localparam logic [7:0] SEG_UPPER [0:25] = '{
		8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h40,
		8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h78,
		8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h40
	};

	localparam logic [7:0] SEG_LOWER [0:25] = '{
		8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h06, 8'h40,
		8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h78,
		8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
	};

	// wiring per (byte, segment), entry = byte*7 + segment; NIL = segment not wired
	localparam logic [2:0] WIRE_HI [0:NUM_MAP-1] = '{
		NIL,  3'd3, 3'd4, NIL,  NIL,  NIL,  NIL,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd3,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd5,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
		NIL,  NIL,  NIL,  NIL,  NIL,  NIL,  3'd5
	};

	localparam logic [2:0] WIRE_LO [0:NUM_MAP-1] = '{
		NIL,  3'd2, 3'd2, NIL,  NIL,  NIL,  NIL,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd1,
		3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5,
		NIL,  NIL,  NIL,  NIL,  NIL,  NIL,  3'd2
	};

	logic [7:0]  shown [0:NUM_BYTES-1];
	logic [2:0]  cur_pos;
	logic [2:0]  scan_row;
	logic [4:0]  char_blink;
	logic [7:0]  icon_blink;
	logic [7:0]  item_value;
	logic [31:0] reg_value;
	pin_drive_t  due;
	pin_drive_t  got;
	pin_drive_t  expected_drives [$];
	int          fail_tally = 0;
	int          queued_total = 0;

	assign mismatch_count = fail_tally;
	assign pending_count  = queued_total;

	function automatic logic [7:0] glyph(input logic [7:0] c);
		logic [7:0] pat;
		pat = DASH;
		if (c >= "0" && c <= "9")
			pat = SEG_DIGIT[c - 8'h30];
		else if (c >= "a" && c <= "z")
			pat = SEG_LOWER[c - 8'h61];
		else if (c >= "A" && c <= "Z")
			pat = SEG_UPPER[c - 8'h41];
		else if (c == ASCII_SPACE)
			pat = 8'h00;
		return pat;
	endfunction

	// segment lines pulled low while pin `row` is the common
	function automatic logic [5:0] lit_lows(input logic [2:0] row, input logic hide);
		logic [5:0] lows;
		logic [7:0] b;
		int i;
		int j;
		int k;
		lows = '0;
		for (i = 0; i < NUM_BYTES; i++) begin
			b = shown[i];
			if (hide) begin
				// a nonzero icon mask takes over blinking of the status byte
				if (icon_blink != 8'h00 && i == STATUS_IDX)
					b = b & ~icon_blink;
				else if (char_blink[i])
					b = 8'h00;
			end
			for (j = 0; j < NUM_SEGS; j++) begin
				k = i * NUM_SEGS + j;
				if (b[j] && WIRE_HI[k] == row && WIRE_LO[k] < NUM_PINS)
					lows[WIRE_LO[k]] = 1'b1;
			end
		end
		return lows;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NUM_BYTES; n++)
				shown[n] = 8'h00;
			cur_pos = 3'd0;
			scan_row = 3'd0;
			char_blink = 5'd0;
			icon_blink = 8'd0;
			expected_drives.delete();
			queued_total = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.high  = m_tdata[5:0];
				got.low   = m_tdata[11:6];
				got.phase = m_tdata[14:12];
				if (expected_drives.size() == 0) begin
					$display("%0t: scan result with nothing expected: expected none, actual %h",
						$time, m_tdata);
					fail_tally++;
				end else begin
					due = expected_drives.pop_front();
					if (got.high !== due.high) begin
						$display("%0t: drive_high expected %h actual %h", $time, due.high, got.high);
						fail_tally++;
					end
					if (got.low !== due.low) begin
						$display("%0t: drive_low expected %h actual %h", $time, due.low, got.low);
						fail_tally++;
					end
					if (got.phase !== due.phase) begin
						$display("%0t: scan_phase expected %0d actual %0d",
							$time, due.phase, got.phase);
						fail_tally++;
					end
				end
			end

			if (psel && penable && pready) begin
				if (pwrite) begin
					if (reg_idx_t'(paddr[2]) == REG_BLINK_CHAR)
						char_blink = pwdata[4:0];
					else
						icon_blink = pwdata[7:0];
				end else begin
					if (reg_idx_t'(paddr[2]) == REG_BLINK_CHAR)
						reg_value = {27'd0, char_blink};
					else
						reg_value = {24'd0, icon_blink};
					if (prdata !== reg_value) begin
						$display("%0t: register %0d readback expected %h actual %h",
							$time, paddr[2], reg_value, prdata);
						fail_tally++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				item_value = s_tdata[7:0];
				case (s_tuser)
					OP_PUT_CHAR: begin
						// colon lights its icon bit and leaves the cursor alone
						if (item_value == ASCII_COLON)
							shown[STATUS_IDX][COLON_BIT] = 1'b1;
						else if (cur_pos < CURSOR_END) begin
							shown[cur_pos] = glyph(item_value);
							cur_pos = cur_pos + 3'd1;
						end
					end
					OP_SET_CURSOR: cur_pos = (item_value > CURSOR_END) ? CURSOR_END : item_value[2:0];
					OP_WRITE_STATUS: shown[STATUS_IDX] = item_value;
					default: begin
						due.high  = 6'd1 << scan_row;
						due.low   = lit_lows(scan_row, s_tdata[8]);
						due.phase = scan_row;
						expected_drives.push_back(due);
						scan_row = (scan_row == LAST_PHASE) ? 3'd0 : scan_row + 3'd1;
					end
				endcase
			end
			queued_total = expected_drives.size();
		end
	end

endmodule

FILE: sim/charlieplexed_segment_display_scan_tb.sv
`timescale 1ns / 100ps
// Testbench top for the display scanner: stimulus, receiver stalls, register setup and verdict
module charlieplexed_segment_display_scan_tb;
	import csds_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // value[7:0], blink_phase[8], zero[15:9]
	logic [1:0]  s_tuser;  // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // drive_high[5:0], drive_low[11:6], scan_phase[14:12], zero[15]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatch_count;
	int pending_count;
	int items_sent = 0;
	int burst_left = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int stall_left = 0;
	int stall_style = 0;
	logic [7:0] stall_tick = 8'd0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	charlieplexed_segment_display_scan DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	scan_drive_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mismatch_count(mismatch_count), .pending_count(pending_count)
	);

	// receiver: long hold-off on request, otherwise stall style changes every segment
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = 160;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_style = $urandom_range(0, 3);
				stall_left = $urandom_range(4, 60);
			end
			stall_left--;
			stall_tick = stall_tick + 8'd1;
			case (stall_style)
				0: m_tready = 1'b1;
				1: m_tready = (stall_tick[1:0] != 2'd0);
				2: m_tready = (stall_tick[1:0] == 2'd0);
				default: m_tready = 1'($urandom_range(0, 1));
			endcase
		end
	end

	// called at a falling edge; returns at a falling edge with the next slot free
	task automatic send_item(input op_t op, input logic [7:0] value, input logic blink);
		int gap;
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {7'd0, blink, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// sender stops until every scan result is back and the pipeline is quiet
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_access(input reg_idx_t idx, input logic wr, input logic [31:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_blink(input logic [4:0] char_mask, input logic [7:0] icon_mask);
		// junk in the unused upper bits must be ignored
		cfg_access(REG_BLINK_CHAR, 1'b1, ($urandom & ~32'h1f) | {27'd0, char_mask});
		cfg_access(REG_BLINK_ICON, 1'b1, ($urandom & ~32'hff) | {24'd0, icon_mask});
		cfg_access(REG_BLINK_CHAR, 1'b0, 32'd0);
		cfg_access(REG_BLINK_ICON, 1'b0, 32'd0);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2: pick_char = 8'h30 + 8'($urandom_range(0, 9));
			3, 4:    pick_char = 8'h61 + 8'($urandom_range(0, 25));
			5, 6:    pick_char = 8'h41 + 8'($urandom_range(0, 25));
			7:       pick_char = " ";
			8:       pick_char = ":";
			default: pick_char = 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_random(input int count);
		int stop_at;
		int n;
		logic blink;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			blink = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// full screen update followed by a scan pass
					send_item(OP_SET_CURSOR, 8'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
					n = $urandom_range(1, 6);
					repeat (n) send_item(OP_PUT_CHAR, pick_char(), 1'($urandom_range(0, 1)));
					if ($urandom_range(0, 2) == 0)
						send_item(OP_WRITE_STATUS, 8'($urandom), 1'($urandom_range(0, 1)));
					n = $urandom_range(6, 12);
					repeat (n) begin
						if ($urandom_range(0, 5) == 0)
							blink = ~blink;
						send_item(OP_SCAN_TICK, 8'($urandom), blink);
					end
				end
				6, 7: begin
					n = $urandom_range(1, 8);
					repeat (n) send_item(OP_SCAN_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
				end
				8: begin
					n = $urandom_range(1, 5);
					repeat (n) send_item(op_t'($urandom_range(0, 3)), 8'($urandom),
						1'($urandom_range(0, 1)));
				end
				default: begin
					// cursor anywhere, including past the end
					send_item(OP_SET_CURSOR, 8'($urandom), blink);
					n = $urandom_range(1, 3);
					repeat (n) send_item(OP_PUT_CHAR, pick_char(), blink);
					n = $urandom_range(1, 3);
					repeat (n) send_item(OP_SCAN_TICK, 8'($urandom), blink);
				end
			endcase
		end
	endtask

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_PUT_CHAR;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(OP_SCAN_TICK, 8'h00, 1'b0);
		send_item(OP_PUT_CHAR, 8'h00, 1'b0);
		send_item(OP_PUT_CHAR, 8'hff, 1'b1);
		send_item(OP_PUT_CHAR, "8", 1'b0);
		send_item(OP_PUT_CHAR, "A", 1'b0);
		send_item(OP_PUT_CHAR, "z", 1'b0);   // lands in the status byte
		send_item(OP_PUT_CHAR, "q", 1'b0);   // cursor at end: dropped
		send_item(OP_PUT_CHAR, ":", 1'b0);
		send_item(OP_SET_CURSOR, 8'hff, 1'b1);
		send_item(OP_PUT_CHAR, " ", 1'b0);
		send_item(OP_SET_CURSOR, 8'h00, 1'b0);
		send_item(OP_PUT_CHAR, " ", 1'b0);
		send_item(OP_PUT_CHAR, "Z", 1'b0);
		send_item(OP_PUT_CHAR, "9", 1'b0);
		send_item(OP_PUT_CHAR, "a", 1'b0);
		send_item(OP_WRITE_STATUS, 8'hff, 1'b0);
		for (int p = 0; p < 6; p++)
			send_item(OP_SCAN_TICK, 8'hff, 1'(p));
		send_item(OP_WRITE_STATUS, 8'h00, 1'b1);
		send_item(OP_SET_CURSOR, 8'h05, 1'b0);
		send_item(OP_SCAN_TICK, 8'h00, 1'b1);

		for (int ph = 0; ph < 5; ph++) begin
			drain_results();
			case (ph)
				0: set_blink(5'h1f, 8'h00);
				1: set_blink(5'h1f, 8'hff);
				2: set_blink(5'h00, 8'h10);
				3: set_blink(5'($urandom), 8'($urandom));
				default: set_blink(5'h10, 8'h00);
			endcase
			if (ph == 0) begin
				// receiver holds off while ticks keep coming, so the block backs up
				hold_req++;
				repeat (16) send_item(OP_SCAN_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
			end
			run_random(96);
		end

		s_tvalid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/csds_pkg.sv
src/csds_render.sv
src/charlieplexed_segment_display_scan.sv
src/csds_checker.sv
sim/scan_drive_checker.sv
sim/charlieplexed_segment_display_scan_tb.sv
